/* rtl/tcgr_pkg.sv */
// Shared types, constants and helpers of the text cell glyph renderer.
package tcgr_pkg;

   localparam int GLYPH_ROWS   = 14;
   localparam int GLYPH_STRIDE = 16;
   localparam int GLYPH_COUNT  = 256;
   localparam int STORE_DEPTH  = GLYPH_STRIDE * GLYPH_COUNT;
   localparam int ROW_W        = $clog2(GLYPH_STRIDE);
   localparam int ADDR_W       = $clog2(STORE_DEPTH);

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

   // command codes carried in tuser
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_RENDER = 1'b1;

   // register indexes of the write port
   localparam logic CSR_SCALE   = 1'b0;
   localparam logic CSR_DIVIDER = 1'b1;

   localparam logic [2:0] SCALE_RESET   = 3'd1;
   localparam logic [7:0] DIVIDER_RESET = 8'd15;

   typedef logic [7:0] color_type;

   // per-line information issued by the sequencer
   typedef struct packed {
      logic [5:0] line;
      logic       blank;
      color_type  fore;
      color_type  back;
      logic       last;
      logic [1:0] scm1;
   } line_info_type;

   // Widen one glyph row; scm1 is scale minus one.
   // Scale 4 leaves the leftmost pixel of each group clear.
   function automatic logic [31:0] widen(input logic [7:0] bits, input logic [1:0] scm1);
      logic [31:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         case (scm1)
            2'd0: m[i] = bits[i];
            2'd1: m[2*i +: 2] = {2{bits[i]}};
            2'd2: m[3*i +: 3] = {3{bits[i]}};
            2'd3: m[4*i +: 3] = {3{bits[i]}};
            default: m = '0;
         endcase
      end
      return m;
   endfunction

endpackage

/* rtl/tcgr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/text_cell_glyph_renderer.sv */
// Text cell glyph renderer top level: glyph store, line sequencer and pixel pipeline.
//
// Usage
//  req_ channel: one transaction is either a glyph store write (tuser = write) that
//  loads one byte, or a render (tuser = render) of one character cell.
//  rsp_ channel: a render yields 14 x scale pixel lines, top first; tlast marks the
//  final line of the cell. A write yields nothing.
//  csr_ port: scale (index 0) and divider colour (index 1), written while idle.
// Throughput
//  The first line of a cell passes the store read, widen and output registers, then one
//  line per cycle while rsp_tready does not stall. A render occupies the line sequencer
//  for 14 x scale lines, taking no transaction meanwhile; writes can go back to back.
//  The sequencer issues one glyph store read per line; output back-pressure sets the rate.
// Reset
//  Clears the sequencer and all pipeline valid bits; scale returns to 1 and the
//  divider colour to 15. The glyph store keeps its contents and is undefined until
//  written.
// Stall
//  While rsp_tready is low with a line pending, every stage and the store read hold;
//  nothing is dropped or repeated.
module text_cell_glyph_renderer
   import tcgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // glyph_addr[11:0], glyph_byte[19:12], char_code[27:20], fore_color[35:28],
   // back_color[43:36], underline[44], underline_fore[45], zero[47:46]
   input  logic [47:0] req_tdata,
   // command[0]
   input  logic        req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // line_index[5:0], pixel_mask[37:6], line_fore[45:38], line_back[53:46], zero[55:54]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   // register write port
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);

   // ---------------- request fields ----------------
   logic [ADDR_W-1:0] req_glyph_addr;
   logic [7:0]        req_glyph_byte;
   logic [7:0]        req_char_code;
   color_type         req_fore;
   color_type         req_back;
   logic              req_ul;
   logic              req_ulf;

   assign req_glyph_addr = req_tdata[11:0];
   assign req_glyph_byte = req_tdata[19:12];
   assign req_char_code  = req_tdata[27:20];
   assign req_fore       = req_tdata[35:28];
   assign req_back       = req_tdata[43:36];
   assign req_ul         = req_tdata[44];
   assign req_ulf        = req_tdata[45];

   // ---------------- configuration registers ----------------
   logic [2:0] scale_ff;
   logic [2:0] scale_in;
   color_type  divider_ff;
   color_type  divider_in;

   always_comb begin
      scale_in   = scale_ff;
      divider_in = divider_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SCALE:   scale_in   = csr_wdata[2:0];
            CSR_DIVIDER: divider_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff   <= SCALE_RESET;
         divider_ff <= DIVIDER_RESET;
      end else begin
         scale_ff   <= scale_in;
         divider_ff <= divider_in;
      end
   end

   // out-of-range scale is clamped to 1..4; held as scale minus one
   logic [1:0] eff_scm1;
   always_comb begin
      if (scale_ff == 3'd0) begin
         eff_scm1 = 2'd0;
      end else if (scale_ff > 3'd4) begin
         eff_scm1 = 2'd3;
      end else begin
         eff_scm1 = 2'(scale_ff - 3'd1);
      end
   end

   // ---------------- handshake ----------------
   logic stall;
   logic req_acc;
   logic wr_acc;
   logic rd_acc;

   assign stall   = rsp_tvalid && !rsp_tready;
   assign req_acc = req_tvalid && req_tready;
   assign wr_acc  = req_acc && (req_tuser == CMD_WRITE);
   assign rd_acc  = req_acc && (req_tuser == CMD_RENDER);

   // ---------------- line sequencer (stage 0) ----------------
   logic             busy_ff,  busy_in;
   logic [ROW_W-1:0] row_ff,   row_in;
   logic [1:0]       sub_ff,   sub_in;
   logic [5:0]       line_ff,  line_in;
   logic [1:0]       scm1_ff,  scm1_in;
   logic [7:0]       code_ff,  code_in;
   color_type        fore_ff,  fore_in;
   color_type        back_ff,  back_in;
   logic             ul_ff,    ul_in;
   logic             ulf_ff,   ulf_in;

   logic             issue;
   logic             sub_end;
   logic             row_end;

   assign req_tready = !busy_ff;
   assign issue      = busy_ff && !stall;
   assign sub_end    = (sub_ff == scm1_ff);
   assign row_end    = (row_ff == LAST_ROW);

   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      sub_in  = sub_ff;
      line_in = line_ff;
      scm1_in = scm1_ff;
      code_in = code_ff;
      fore_in = fore_ff;
      back_in = back_ff;
      ul_in   = ul_ff;
      ulf_in  = ulf_ff;
      if (rd_acc) begin
         // a new cell starts from the top with a cleared line count
         busy_in = 1'b1;
         row_in  = '0;
         sub_in  = '0;
         line_in = '0;
         scm1_in = eff_scm1;
         code_in = req_char_code;
         fore_in = req_fore;
         back_in = req_back;
         ul_in   = req_ul;
         ulf_in  = req_ulf;
      end else if (issue) begin
         line_in = line_ff + 6'd1;
         if (sub_end) begin
            sub_in = '0;
            if (row_end) begin
               busy_in = 1'b0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
         sub_ff  <= '0;
         line_ff <= '0;
         scm1_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         row_ff  <= row_in;
         sub_ff  <= sub_in;
         line_ff <= line_in;
         scm1_ff <= scm1_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      fore_ff <= fore_in;
      back_ff <= back_in;
      ul_ff   <= ul_in;
      ulf_ff  <= ulf_in;
   end

   // line information: colours overridden on the last glyph row when underline or underline_fore is set
   line_info_type issue_info;
   always_comb begin
      issue_info.line  = line_ff;
      issue_info.blank = (scm1_ff >= 2'd2) && (sub_ff == 2'd0);
      issue_info.fore  = fore_ff;
      issue_info.back  = back_ff;
      issue_info.last  = row_end && sub_end;
      issue_info.scm1  = scm1_ff;
      if (row_end) begin
         if (ul_ff) begin
            issue_info.fore = divider_ff;
            issue_info.back = divider_ff;
         end else if (ulf_ff) begin
            issue_info.back = fore_ff;
         end
      end
   end

   // ---------------- glyph store ----------------
   logic [7:0] glyph_bits;

   tcgr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_acc),
      .wr_addr (req_glyph_addr),
      .wr_data (req_glyph_byte),
      .rd_en   (!stall),
      .rd_addr ({code_ff, row_ff}),
      .rd_data (glyph_bits)
   );

   // ---------------- stage 1: store read ----------------
   logic          s1_valid_ff, s1_valid_in;
   line_info_type s1_info_ff;

   assign s1_valid_in = stall ? s1_valid_ff : issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_info_ff <= issue_info;
      end
   end

   // ---------------- stage 2: widen ----------------
   logic          s2_valid_ff, s2_valid_in;
   line_info_type s2_info_ff;
   logic [31:0]   s2_mask_ff, s2_mask_in;

   assign s2_valid_in = stall ? s2_valid_ff : s1_valid_ff;
   // blank lines at scale 3 and 4 carry no pixels
   assign s2_mask_in  = s1_info_ff.blank ? '0 : widen(glyph_bits, s1_info_ff.scm1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s2_info_ff <= s1_info_ff;
         s2_mask_ff <= s2_mask_in;
      end
   end

   // ---------------- stage 3: output register ----------------
   logic        out_valid_ff, out_valid_in;
   logic [55:0] out_data_ff;
   logic        out_last_ff;

   assign out_valid_in = stall ? out_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         out_data_ff <= {2'b00, s2_info_ff.back, s2_info_ff.fore, s2_mask_ff,
                         s2_info_ff.line};
         out_last_ff <= s2_info_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // ---------------- assertions ----------------
   a_render_start: assert property (@(posedge clock) disable iff (reset)
      rd_acc |=> busy_ff && row_ff == '0 && sub_ff == 2'd0 && line_ff == 6'd0)
      else $error("render did not start from the top of the cell");

   a_line_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff && row_ff == '0 && sub_ff == 2'd0 |-> line_ff == 6'd0)
      else $error("line count out of step with row and sub-line");

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> sub_ff <= scm1_ff)
      else $error("sub-line beyond scale");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> s1_valid_ff == $past(s1_valid_ff) && s2_valid_ff == $past(s2_valid_ff)
                && rsp_tvalid)
      else $error("pipeline moved during a stall");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the text cell glyph renderer.
`timescale 1ns / 100ps

module tb
   import tcgr_pkg::*;
();

   // Timing and run control
   localparam int unsigned CYCLE_LIMIT  = 300000;  // far above the slowest correct run
   localparam int          IDLE_PERCENT = 13;      // chance of a gap on either side
   localparam int          SETTLE       = 8;       // cycles allowed after the last line
   localparam int          PHASE_ITEMS  = 36;      // random transactions per register setting
   localparam int          HOLD_CYCLES  = 400;     // long receiver hold-off

   // One expected pixel line of a cell
   typedef struct packed {
      logic [5:0]  line;
      logic [31:0] mask;
      color_type   fore;
      color_type   back;
      logic        last;
   } pixel_line_type;

   // Every input starts at a known value; reset held from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        req_tuser  = CMD_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic        csr_addr   = CSR_SCALE;
   logic [7:0]  csr_wdata  = '0;

   // Predictor state: own copy of the glyph store and of both registers
   logic [7:0]     glyph_copy [STORE_DEPTH];
   logic [2:0]     scale_reg   = SCALE_RESET;
   color_type      divider_reg = DIVIDER_RESET;
   pixel_line_type pending_lines [$];
   logic [7:0]     loaded_codes [$];    // codes whose 14 rows have all been written

   // Run control shared by the stimulus and the receiver
   bit          quiet_mode    = 1'b0;
   int          stall_request = 0;
   int          hold_left     = 0;
   int unsigned cycle_count   = 0;

   // Tallies
   int error_count    = 0;
   int lines_checked  = 0;
   int renders_sent   = 0;
   int writes_sent    = 0;
   int settings_used  = 0;

   // Fixed glyph for the directed part: full, empty, single edge bits, alternations
   logic [7:0] edge_glyph [GLYPH_ROWS] = '{
      8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0,
      8'h0F, 8'hC3, 8'h3C, 8'h81, 8'h7E, 8'h18, 8'hE7
   };

   text_cell_glyph_renderer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a missing line or a hung handshake ends up here
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d lines still awaited",
               cycle_count, pending_lines.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // Line predictor: expands one render into its 14 x scale pixel lines
   // ------------------------------------------------------------------
   function automatic void render_cell_lines(input logic [7:0] code, input color_type fore,
                                             input color_type back, input logic ul,
                                             input logic ul_fore);
      logic [2:0]     sc;
      logic [3:0]     group;
      logic [7:0]     bits;
      logic [31:0]    wide;
      logic [5:0]     line_no;
      color_type      fg;
      color_type      bg;
      pixel_line_type pl;
      // out-of-range scale saturates: 0 acts as 1, 5..7 as 4
      if (scale_reg == 3'd0) sc = 3'd1;
      else if (scale_reg > 3'd4) sc = 3'd4;
      else sc = scale_reg;
      // scale 4 keeps the leftmost pixel of each group as background
      group   = (sc == 3'd4) ? 4'b0111 : 4'((1 << sc) - 1);
      line_no = '0;
      for (int row = 0; row < GLYPH_ROWS; row++) begin
         bits = glyph_copy[{code, 4'(row)}];
         wide = '0;
         for (int i = 0; i < 8; i++) begin
            if (bits[i]) wide |= 32'(group) << (i * sc);
         end
         fg = fore;
         bg = back;
         // last glyph row: underline wins over underline-foreground
         if (row == GLYPH_ROWS - 1) begin
            if (ul) begin
               fg = divider_reg;
               bg = divider_reg;
            end else if (ul_fore) begin
               bg = fg;
            end
         end
         for (int sub = 0; sub < sc; sub++) begin
            pl.line = line_no;
            // scales 3 and 4 open each row with a blank line that still carries colours
            pl.mask = (sc >= 3'd3 && sub == 0) ? 32'd0 : wide;
            pl.fore = fg;
            pl.back = bg;
            pl.last = (row == GLYPH_ROWS - 1) && (sub == sc - 1);
            pending_lines.push_back(pl);
            line_no++;
         end
      end
   endfunction

   // tdata layout: addr, byte, code, fore, back, underline, underline_fore, pad
   function automatic logic [47:0] pack_req(input logic [11:0] addr, input logic [7:0] gbyte,
                                            input logic [7:0] code, input color_type fore,
                                            input color_type back, input logic ul,
                                            input logic ul_fore);
      return {2'b00, ul_fore, ul, back, fore, code, gbyte, addr};
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Entered and left at a falling edge. tvalid stays high on exit so a
   // following transaction can go out without a bubble; callers that stop
   // sending must lower it (see wait_cells_drained).
   task automatic send_item(input logic cmd, input logic [47:0] data);
      if (!quiet_mode && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      // transaction taken at this edge: update the predictor in order
      if (cmd == CMD_WRITE) begin
         glyph_copy[data[11:0]] = data[19:12];
         writes_sent++;
      end else begin
         render_cell_lines(data[27:20], data[35:28], data[43:36], data[44], data[45]);
         renders_sent++;
      end
      @(negedge clock);
   endtask

   // Glyph write; the render fields carry junk that the block must ignore
   task automatic write_glyph_byte(input logic [11:0] addr, input logic [7:0] gbyte);
      send_item(CMD_WRITE, pack_req(addr, gbyte, 8'($urandom), 8'($urandom), 8'($urandom),
                                    1'($urandom), 1'($urandom)));
   endtask

   // Render; the write fields carry junk that the block must ignore
   task automatic render_cell(input logic [7:0] code, input color_type fore,
                              input color_type back, input logic ul, input logic ul_fore);
      send_item(CMD_RENDER, pack_req(12'($urandom), 8'($urandom), code, fore, back,
                                     ul, ul_fore));
   endtask

   // Loads all 14 rows of a code; random content leans on empty and full rows now and then
   task automatic load_glyph(input logic [7:0] code, input bit use_edge_glyph);
      logic [7:0] gbyte;
      for (int row = 0; row < GLYPH_ROWS; row++) begin
         if (use_edge_glyph) gbyte = edge_glyph[row];
         else begin
            case ($urandom_range(9))
               0:       gbyte = 8'h00;
               1:       gbyte = 8'hFF;
               default: gbyte = 8'($urandom);
            endcase
         end
         write_glyph_byte({code, 4'(row)}, gbyte);
      end
      loaded_codes.push_back(code);
   endtask

   // Stop offering, wait until every predicted line has arrived, then let the
   // write pipeline settle so the block is truly idle
   task automatic wait_cells_drained();
      req_tvalid <= 1'b0;
      while (pending_lines.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Register write, only ever issued while the block is idle
   task automatic program_reg(input logic idx, input logic [7:0] value);
      wait_cells_drained();
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_SCALE) scale_reg = value[2:0];
      else divider_reg = value;
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------
   // Receiver: random back-pressure, quiet stretches and a long hold-off,
   // the hold-off counted down here in its own process
   always @(negedge clock) begin
      if (stall_request != 0) begin
         hold_left     = stall_request;
         stall_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (quiet_mode) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at cycle %0d: %s got 0x%0h, expected 0x%0h",
               cycle_count, what, got, want);
      error_count++;
   endtask

   // Checker: each accepted line against the oldest prediction, field by field
   always @(posedge clock) begin : line_check
      pixel_line_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lines.size() == 0) begin
            report_mismatch("line with no render pending, line_index", 32'(rsp_tdata[5:0]), 0);
         end else begin
            want = pending_lines.pop_front();
            lines_checked++;
            if (rsp_tdata[5:0] !== want.line)
               report_mismatch("line_index", 32'(rsp_tdata[5:0]), 32'(want.line));
            if (rsp_tdata[37:6] !== want.mask)
               report_mismatch("pixel_mask", rsp_tdata[37:6], want.mask);
            if (rsp_tdata[45:38] !== want.fore)
               report_mismatch("line_fore", 32'(rsp_tdata[45:38]), 32'(want.fore));
            if (rsp_tdata[53:46] !== want.back)
               report_mismatch("line_back", 32'(rsp_tdata[53:46]), 32'(want.back));
            if (rsp_tlast !== want.last)
               report_mismatch("last_line", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Reset values of both registers, field extremes and the underline cases
   task automatic test_reset_and_extremes();
      load_glyph(8'hFF, 1'b1);
      write_glyph_byte(12'hFFF, 8'hFF);    // unused row 15 of the top code
      write_glyph_byte(12'h000, 8'h00);
      // scale 1 and divider 15 straight out of reset
      render_cell(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
      render_cell(8'hFF, 8'h12, 8'h34, 1'b1, 1'b0);
      render_cell(8'hFF, 8'h56, 8'h78, 1'b0, 1'b1);
      render_cell(8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1);   // underline takes precedence
   endtask

   // Scales 2 to 4 once each, with divider extremes on underlined rows
   task automatic test_each_scale();
      program_reg(CSR_DIVIDER, 8'h00);
      for (int s = 2; s <= 4; s++) begin
         program_reg(CSR_SCALE, 8'(s));
         settings_used++;
         render_cell(8'hFF, 8'($urandom), 8'($urandom), 1'b1, 1'($urandom));
      end
      program_reg(CSR_DIVIDER, 8'hFF);
      render_cell(8'hFF, 8'hA5, 8'h5A, 1'b1, 1'b0);
   endtask

   // Receiver holds off while renders keep coming, so the block fills and
   // stalls its request side; scale is 4 here so every cell is 56 lines
   task automatic test_backpressure();
      stall_request = HOLD_CYCLES;
      for (int n = 0; n < 6; n++)
         render_cell(8'hFF, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      wait_cells_drained();
   endtask

   // Register settings walked in phases: every legal scale, the out-of-range
   // codes 0, 5 and 7, and divider extremes. Most traffic is glyph loads followed by renders
   // of loaded codes; stray writes anywhere in the store act as noise.
   task automatic test_random_phases();
      logic [2:0] phase_scale [7] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd7};
      int         sent_before;
      int         pick;
      for (int ph = 0; ph < 7; ph++) begin
         // upper bits of the scale write are don't-care junk
         program_reg(CSR_SCALE, {5'($urandom), phase_scale[ph]});
         case (ph)
            1:       program_reg(CSR_DIVIDER, 8'h00);
            2:       program_reg(CSR_DIVIDER, 8'hFF);
            default: program_reg(CSR_DIVIDER, 8'($urandom));
         endcase
         settings_used++;
         quiet_mode  = (ph == 0);   // first phase runs with no gaps on either side
         sent_before = renders_sent + writes_sent;
         while (renders_sent + writes_sent - sent_before < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (loaded_codes.size() < 3 || pick < 12) begin
               load_glyph(8'($urandom), 1'b0);
            end else if (pick < 22) begin
               write_glyph_byte(12'($urandom), 8'($urandom));
            end else if (pick < 25) begin
               wait_cells_drained();   // sender pauses until all lines are in
            end else begin
               render_cell(loaded_codes[$urandom_range(loaded_codes.size() - 1)],
                           8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
         end
         quiet_mode = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_and_extremes();
      settings_used++;
      test_each_scale();
      test_backpressure();
      test_random_phases();

      wait_cells_drained();
      repeat (20) @(negedge clock);   // any stray line would be flagged by the checker

      $display("Run covered %0d renders and %0d glyph writes over %0d register settings,",
               renders_sent, writes_sent, settings_used);
      $display("including out-of-range scales and a %0d-cycle receiver hold-off;",
               HOLD_CYCLES);
      $display("%0d lines checked.", lines_checked);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* text_cell_glyph_renderer.f */
rtl/tcgr_pkg.sv
rtl/tcgr_ram.sv
rtl/text_cell_glyph_renderer.sv
tb/tb.sv
